>>> src/ega_rle_pkg.sv
// shared types and constants for the escape-byte run-length span decoder
// no dependencies; imported by the core, front, back and checker modules
package ega_rle_pkg;

  // default limits handed to the top level parameters
  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int MAX_HEIGHT_DEF = 1024;

  // at most this many spans are reported for one input byte
  localparam int MAX_SPANS = 3;

  // queue depths between the parts
  localparam int CMD_FIFO_DEPTH  = 4;
  localparam int SPAN_FIFO_DEPTH = 4;

  // register reset values
  localparam logic [7:0]  ESCAPE_RESET = 8'h02;
  localparam logic [10:0] WIDTH_RESET  = 11'd320;
  localparam logic [10:0] HEIGHT_RESET = 11'd200;

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_ESCAPE_CODE  = 2'd0,
    REG_IMAGE_WIDTH  = 2'd1,
    REG_IMAGE_HEIGHT = 2'd2
  } cfg_reg_t;

  // parser phase, one-hot
  typedef enum logic [2:0] {
    PH_LITERAL = 3'b001,
    PH_COUNT   = 3'b010,
    PH_COLOR   = 3'b100
  } parse_phase_t;

  // one input transaction
  typedef struct packed {
    logic [7:0] stream_byte;
    logic       image_start;
  } byte_item_t;

  // one result transaction
  typedef struct packed {
    logic [9:0] row;
    logic [9:0] start_x;
    logic [9:0] pair_count;
    logic [3:0] left_color;
    logic [3:0] right_color;
    logic       last_span;
  } span_item_t;

  // classified work handed from the front to the back
  typedef struct packed {
    logic       restart;
    logic [7:0] count;
    logic [7:0] color;
  } run_cmd_t;

  // configuration seen by the parts
  typedef struct packed {
    logic [7:0]  escape_code;
    logic [10:0] image_width;
    logic [10:0] image_height;
  } cfg_t;

endpackage

>>> src/ega_escape_rle_span_decoder_core.sv
// path: a literal byte's span is registered in the command queue and then in the span queue
//   before it is on the result ports and can be popped
// throughput: one byte per cycle while the command queue is not full; a run is walked one row
//   segment per back-end step, while the parser keeps taking bytes until the command queue fills
// reset: synchronous rst clears parser, cursor and both queues, and loads
//   escape code 2, width 320 and height 200
module ega_escape_rle_span_decoder_core #(
  parameter int MAX_WIDTH  = ega_rle_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = ega_rle_pkg::MAX_HEIGHT_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    push,
  input  ega_rle_pkg::byte_item_t byte_item,
  output logic                    full,
  input  logic                    pop,
  output ega_rle_pkg::span_item_t span_item,
  output logic                    empty,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [1:0]              cfg_index,
  input  logic [10:0]             cfg_data
);

  import ega_rle_pkg::*;

  cfg_t       cfg;
  logic       item_valid;
  logic       cmd_push;
  run_cmd_t   cmd_in;
  logic       cmd_full;
  logic       cmd_pop;
  run_cmd_t   cmd_out;
  logic       cmd_empty;
  logic       span_push;
  span_item_t span_in;
  logic       span_full;

  assign cfg_ready  = 1'b1;
  assign full       = cmd_full;
  assign item_valid = push && !cmd_full;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.escape_code  <= ESCAPE_RESET;
      cfg.image_width  <= WIDTH_RESET;
      cfg.image_height <= HEIGHT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_ESCAPE_CODE:  cfg.escape_code  <= cfg_data[7:0];
        REG_IMAGE_WIDTH:  cfg.image_width  <= cfg_data;
        REG_IMAGE_HEIGHT: cfg.image_height <= cfg_data;
        default:          cfg <= cfg;
      endcase
    end
  end

  // byte parser
  ega_rle_front u_front (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (item_valid),
    .item        (byte_item),
    .escape_code (cfg.escape_code),
    .cmd_push    (cmd_push),
    .cmd         (cmd_in)
  );

  // command queue between parser and span walker
  ega_rle_fifo #(
    .WIDTH ($bits(run_cmd_t)),
    .DEPTH (CMD_FIFO_DEPTH)
  ) u_cmd_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (cmd_push && item_valid),
    .wdata (cmd_in),
    .full  (cmd_full),
    .pop   (cmd_pop),
    .rdata (cmd_out),
    .empty (cmd_empty)
  );

  // span walker
  ega_rle_back #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .cmd       (cmd_out),
    .cmd_empty (cmd_empty),
    .cmd_pop   (cmd_pop),
    .span_push (span_push),
    .span      (span_in),
    .span_full (span_full)
  );

  // result queue
  ega_rle_fifo #(
    .WIDTH ($bits(span_item_t)),
    .DEPTH (SPAN_FIFO_DEPTH)
  ) u_span_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (span_push),
    .wdata (span_in),
    .full  (span_full),
    .pop   (pop),
    .rdata (span_item),
    .empty (empty)
  );

endmodule

>>> src/ega_rle_fifo.sv
// small synchronous queue with count-based full and empty
// no package dependencies; used for the command queue and the span queue
module ega_rle_fifo #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] storage [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = storage[rd_ptr];

  // entry write
  always_ff @(posedge clk) begin
    if (do_push) begin
      storage[wr_ptr] <= wdata;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + CW'(1);
        2'b01:   count <= count - CW'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

>>> src/ega_rle_front.sv
// front end: byte parser that tracks the escape phase and emits run commands
// depends on ega_rle_pkg
module ega_rle_front (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    item_valid,
  input  ega_rle_pkg::byte_item_t item,
  input  logic [7:0]              escape_code,
  output logic                    cmd_push,
  output ega_rle_pkg::run_cmd_t   cmd
);

  import ega_rle_pkg::*;

  parse_phase_t phase;
  parse_phase_t phase_next;
  logic [7:0]   held_count;
  logic [7:0]   held_count_next;
  parse_phase_t phase_eff;
  logic [7:0]   held_eff;

  // image start forces the literal phase before the byte is looked at
  assign phase_eff = item.image_start ? PH_LITERAL : phase;
  assign held_eff  = item.image_start ? 8'd0 : held_count;

  // classify the byte
  always_comb begin
    phase_next      = phase_eff;
    held_count_next = held_eff;
    cmd_push        = 1'b0;
    cmd.restart     = item.image_start;
    cmd.count       = 8'd1;
    cmd.color       = item.stream_byte;
    case (phase_eff)
      PH_COUNT: begin
        held_count_next = item.stream_byte;
        phase_next      = PH_COLOR;
      end
      PH_COLOR: begin
        phase_next      = PH_LITERAL;
        held_count_next = 8'd0;
        cmd.count       = held_eff;
        cmd_push        = 1'b1;
      end
      default: begin
        phase_next = PH_LITERAL;
        if (item.stream_byte == escape_code) begin
          // escape: only a cursor restart needs to reach the back end
          phase_next = PH_COUNT;
          cmd.count  = 8'd0;
          cmd_push   = item.image_start;
        end else begin
          cmd_push = 1'b1;
        end
      end
    endcase
  end

  // parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_LITERAL;
      held_count <= 8'd0;
    end else if (item_valid) begin
      phase      <= phase_next;
      held_count <= held_count_next;
    end
  end

endmodule

>>> src/ega_rle_back.sv
// back end: walks the cursor over each run, one row segment per cycle while the span queue is not full
// depends on ega_rle_pkg; reads commands from the command queue
module ega_rle_back #(
  parameter int MAX_WIDTH  = ega_rle_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = ega_rle_pkg::MAX_HEIGHT_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  ega_rle_pkg::cfg_t       cfg,
  input  ega_rle_pkg::run_cmd_t   cmd,
  input  logic                    cmd_empty,
  output logic                    cmd_pop,
  output logic                    span_push,
  output ega_rle_pkg::span_item_t span,
  input  logic                    span_full
);

  import ega_rle_pkg::*;

  localparam int XW = $clog2(MAX_WIDTH + 1);
  localparam int YW = $clog2(MAX_HEIGHT + 1);
  localparam int CW = (XW > 8) ? XW : 8;

  logic          busy;
  logic [7:0]    n_left;
  logic [7:0]    color;
  logic [1:0]    k;
  logic [XW-1:0] cursor_x;
  logic [YW-1:0] cursor_y;

  logic [XW-1:0] w_clamp;
  logic [XW-1:0] w_eff;
  logic [YW-1:0] h_eff;

  logic          src_valid;
  logic [7:0]    src_n;
  logic [7:0]    src_color;
  logic [1:0]    src_k;
  logic [XW-1:0] cx_in;
  logic [YW-1:0] cy_in;
  logic          step;
  logic          zero;

  logic          wrap0;
  logic [XW-1:0] cx0;
  logic [YW-1:0] cy0;
  logic [XW-1:0] room;
  logic [CW-1:0] take_c;
  logic [XW-1:0] cx1;
  logic [7:0]    n1;
  logic          wrap1;
  logic [XW-1:0] cx2;
  logic [YW-1:0] cy2;
  logic          emit;
  logic [1:0]    k_inc;
  logic          more;

  // effective width: clamped and made even
  always_comb begin
    if (cfg.image_width < 11'd2) begin
      w_clamp = XW'(2);
    end else if (32'(cfg.image_width) > 32'(MAX_WIDTH)) begin
      w_clamp = XW'(MAX_WIDTH);
    end else begin
      w_clamp = XW'(cfg.image_width);
    end
    w_eff = w_clamp & ~XW'(1);
  end

  // effective height: clamped
  always_comb begin
    if (cfg.image_height == 11'd0) begin
      h_eff = YW'(1);
    end else if (32'(cfg.image_height) > 32'(MAX_HEIGHT)) begin
      h_eff = YW'(MAX_HEIGHT);
    end else begin
      h_eff = YW'(cfg.image_height);
    end
  end

  // work source: the run in progress, else the queue head
  assign src_valid = busy || !cmd_empty;
  assign src_n     = busy ? n_left : cmd.count;
  assign src_color = busy ? color : cmd.color;
  assign src_k     = busy ? k : 2'd0;
  assign cx_in     = (!busy && cmd.restart) ? '0 : cursor_x;
  assign cy_in     = (!busy && cmd.restart) ? '0 : cursor_y;
  assign step      = src_valid && !span_full;
  assign cmd_pop   = step && !busy;
  assign zero      = (src_n == 8'd0);

  // one row segment of the run
  always_comb begin
    wrap0  = (cx_in >= w_eff);
    cx0    = wrap0 ? '0 : cx_in;
    cy0    = (wrap0 && (cy_in < h_eff)) ? cy_in + YW'(1) : cy_in;
    room   = (w_eff - cx0) >> 1;
    take_c = (CW'(src_n) < CW'(room)) ? CW'(src_n) : CW'(room);
    cx1    = cx0 + XW'({take_c, 1'b0});
    n1     = src_n - 8'(take_c);
    wrap1  = (cx1 >= w_eff);
    cx2    = wrap1 ? '0 : cx1;
    cy2    = (wrap1 && (cy0 < h_eff)) ? cy0 + YW'(1) : cy0;
    emit   = (cy0 < h_eff) && (src_k < 2'(MAX_SPANS));
    k_inc  = src_k + 2'd1;
    // another span follows only if rows and span slots remain
    more   = (n1 != 8'd0) && (cy2 < h_eff) && (k_inc < 2'(MAX_SPANS));
  end

  // span out
  assign span_push        = step && !zero && emit;
  assign span.row         = 10'(cy0);
  assign span.start_x     = 10'(cx0);
  assign span.pair_count  = 10'(take_c);
  assign span.left_color  = src_color[7:4];
  assign span.right_color = src_color[3:0];
  assign span.last_span   = !more;

  // run payload
  always_ff @(posedge clk) begin
    if (step && !zero) begin
      n_left <= n1;
      color  <= src_color;
    end
  end

  // cursor and run control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      k        <= 2'd0;
      cursor_x <= '0;
      cursor_y <= '0;
    end else if (step) begin
      if (zero) begin
        cursor_x <= cx_in;
        cursor_y <= cy_in;
        busy     <= 1'b0;
      end else begin
        cursor_x <= cx2;
        cursor_y <= cy2;
        k        <= emit ? k_inc : src_k;
        busy     <= (n1 != 8'd0);
      end
    end
  end

endmodule

>>> src/ega_rle_checker.sv
// port-level checks for the span decoder top level, attached by bind
// depends on ega_rle_pkg and ega_escape_rle_span_decoder_core
module ega_rle_checker (
  input logic                    clk,
  input logic                    rst,
  input logic                    full,
  input logic                    pop,
  input logic                    empty,
  input ega_rle_pkg::span_item_t span_item
);

  import ega_rle_pkg::*;

  // after reset the span queue is empty and the command queue is not full
  a_reset_drained: assert property (@(posedge clk) rst |=> (empty && !full))
    else $error("queues not drained after reset");

  // a waiting span never has zero pairs
  a_pairs_nonzero: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (span_item.pair_count != 10'd0))
    else $error("span with zero pairs");

  // spans start on a pair boundary
  a_start_even: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (span_item.start_x[0] == 1'b0))
    else $error("span starts on odd column");

  // a span never runs past the widest row
  a_fits_row: assert property (@(posedge clk) disable iff (rst)
    !empty |-> ((11'(span_item.start_x) + {span_item.pair_count, 1'b0}) <= 11'd1024))
    else $error("span crosses the row end");

  // a span that is not taken stays put
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(span_item)))
    else $error("waiting span changed");

endmodule

bind ega_escape_rle_span_decoder_core ega_rle_checker u_ega_rle_checker (
  .clk       (clk),
  .rst       (rst),
  .full      (full),
  .pop       (pop),
  .empty     (empty),
  .span_item (span_item)
);
